[rtl/rrhc_pkg.sv]
// Package for the record region hit counter.
// Types, constants and small helper functions shared by the rtl files other than rrhc_ram.
// No dependencies.
package rrhc_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW         = 6;
  localparam int NameChars    = 8;
  localparam int NameW        = 64;
  localparam int LenW         = 4;
  localparam logic [31:0] MarginReset = 32'd5000;
  localparam logic [31:0] Max32       = 32'hFFFF_FFFF;

  // func codes
  localparam logic [1:0] FuncLoad  = 2'd0;
  localparam logic [1:0] FuncByte  = 2'd1;
  localparam logic [1:0] FuncQuery = 2'd2;

  // characters of interest
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChAt      = 8'h40;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [2:0] PosField  = 3'd3;
  localparam logic [2:0] TabSat    = 3'd4;

  localparam logic KindRecord = 1'b0;
  localparam logic KindQuery  = 1'b1;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       data_byte;
    logic [IdxW-1:0]  entry_index;
    logic [NameW-1:0] entry_name;
    logic [LenW-1:0]  name_length;
    logic [31:0]      region_start;
    logic [31:0]      region_end;
  } in_word_t;

  typedef struct packed {
    logic            kind;
    logic [IdxW-1:0] matched_index;
    logic            name_known;
    logic            in_window;
    logic            position_bad;
    logic [31:0]     record_position;
    logic [31:0]     hit_count;
    logic [31:0]     total_count;
    logic [31:0]     unmatched_count;
  } out_word_t;

  // table entry as held in the name memory
  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [NameW-1:0] name;
    logic [31:0]      start;
    logic [31:0]      stop;
  } entry_t;

  typedef struct packed {
    logic [31:0] hits;
    logic [31:0] totals;
  } count_t;

  typedef struct packed {
    logic take;       // input word accepted
    logic name_rd;    // read table entry at scan slot
    logic cnt_rd;     // read counts at scan slot
    logic scan_next;  // advance scan slot
    logic upd;        // matched record: update counts, load result
    logic unm;        // unmatched record: load result
    logic qry;        // query answer: load result
  } cmd_t;

  typedef struct packed {
    logic tally_req;  // newline word with name and position collected
    logic too_long;   // current name overflowed
    logic is_query;
    logic hit;        // scan slot matches
    logic scan_last;
    logic out_free;
  } sts_t;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StSrd  = 6'b000010,
    StScmp = 6'b000100,
    StCwin = 6'b001000,
    StUout = 6'b010000,
    StQout = 6'b100000
  } state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == Max32) ? v : v + 32'd1;
  endfunction

  function automatic logic [NameW-1:0] name_mask(input logic [LenW-1:0] len);
    logic [NameW-1:0] m;
    m = '0;
    for (int b = 0; b < NameChars; b++) begin
      if (LenW'(b) < len) m[8*b +: 8] = 8'hFF;
    end
    name_mask = m;
  endfunction

endpackage

[rtl/rrhc_ram.sv]
// Generic single port RAM with registered read.
// No dependencies.
module rrhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rrhc_ctrl.sv]
// Controller state machine of the record region hit counter.
// Depends on rrhc_pkg.
module rrhc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rrhc_pkg::sts_t  sts_i,
  output rrhc_pkg::cmd_t  cmd_o
);

  rrhc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrhc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != rrhc_pkg::StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      rrhc_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.tally_req) begin
            state_d = sts_i.too_long ? rrhc_pkg::StUout : rrhc_pkg::StSrd;
          end else if (sts_i.is_query) begin
            state_d = rrhc_pkg::StQout;
          end
        end
      end
      rrhc_pkg::StSrd: begin
        cmd_o.name_rd = 1'b1;
        state_d = rrhc_pkg::StScmp;
      end
      rrhc_pkg::StScmp: begin
        cmd_o.cnt_rd = 1'b1;
        if (sts_i.hit) begin
          state_d = rrhc_pkg::StCwin;
        end else if (sts_i.scan_last) begin
          state_d = rrhc_pkg::StUout;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d = rrhc_pkg::StSrd;
        end
      end
      rrhc_pkg::StCwin: begin
        if (sts_i.out_free) begin
          cmd_o.upd = 1'b1;
          state_d = rrhc_pkg::StIdle;
        end
      end
      rrhc_pkg::StUout: begin
        if (sts_i.out_free) begin
          cmd_o.unm = 1'b1;
          state_d = rrhc_pkg::StIdle;
        end
      end
      rrhc_pkg::StQout: begin
        if (sts_i.out_free) begin
          cmd_o.qry = 1'b1;
          state_d = rrhc_pkg::StIdle;
        end
      end
      default: begin
        state_d = rrhc_pkg::StIdle;
      end
    endcase
  end

endmodule

[rtl/rrhc_dp.sv]
// Datapath of the record region hit counter: byte parser, table memories,
// scan slot, window check, counters and output register.
// Depends on rrhc_pkg and rrhc_ram.
module rrhc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rrhc_pkg::in_word_t  in_word_i,
  input  logic                cfg_valid_i,
  input  logic [31:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rrhc_pkg::out_word_t out_word_o,
  input  rrhc_pkg::cmd_t      cmd_i,
  output rrhc_pkg::sts_t      sts_o
);

  localparam int IdxW = rrhc_pkg::IdxW;

  // parser state
  logic                        line_active_q, star_seen_q, too_long_q;
  logic                        pos_chars_q, digits_ended_q, pos_invalid_q;
  logic [2:0]                  tab_count_q;
  logic [rrhc_pkg::NameW-1:0]  name_buf_q;
  logic [rrhc_pkg::LenW-1:0]   name_chars_q;
  logic [31:0]                 pos_q;

  // snapshot of the record being tallied
  logic [rrhc_pkg::NameW-1:0]  sn_name_q;
  logic [rrhc_pkg::LenW-1:0]   sn_len_q;
  logic [31:0]                 sn_pos_q;
  logic                        sn_inv_q;

  logic [31:0]                 margin_q, unm_q;
  logic [IdxW-1:0]             scan_q, qidx_q;
  logic                        entry_valid_q [rrhc_pkg::TableEntries];
  logic                        out_valid_q;
  rrhc_pkg::out_word_t         out_q;

  logic [7:0]  c;
  logic        is_byte, is_load, is_query, is_digit;
  logic [35:0] p10;
  logic [31:0] pos_next;

  assign c        = in_word_i.data_byte;
  assign is_byte  = cmd_i.take && (in_word_i.func == rrhc_pkg::FuncByte);
  assign is_load  = cmd_i.take && (in_word_i.func == rrhc_pkg::FuncLoad);
  assign is_query = cmd_i.take && (in_word_i.func == rrhc_pkg::FuncQuery);
  assign is_digit = (c >= rrhc_pkg::ChZero) && (c <= rrhc_pkg::ChNine);
  assign p10      = {1'b0, pos_q, 3'b000} + {3'b000, pos_q, 1'b0}
                  + {28'd0, c - rrhc_pkg::ChZero};
  assign pos_next = (|p10[35:32]) ? rrhc_pkg::Max32 : p10[31:0];

  // memories
  rrhc_pkg::entry_t ent_wdata, ent_rdata;
  rrhc_pkg::count_t cnt_wdata, cnt_rdata, cnt_new;
  logic             cnt_en, cnt_we;
  logic [IdxW-1:0]  ent_addr, cnt_addr;

  assign ent_wdata.len   = in_word_i.name_length;
  assign ent_wdata.name  = in_word_i.entry_name & rrhc_pkg::name_mask(in_word_i.name_length);
  assign ent_wdata.start = in_word_i.region_start;
  assign ent_wdata.stop  = in_word_i.region_end;
  assign ent_addr        = is_load ? in_word_i.entry_index : scan_q;

  rrhc_ram #(
    .WIDTH ($bits(rrhc_pkg::entry_t)),
    .DEPTH (rrhc_pkg::TableEntries)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .en_i    (is_load || cmd_i.name_rd),
    .we_i    (is_load),
    .addr_i  (ent_addr),
    .wdata_i (ent_wdata),
    .rdata_o (ent_rdata)
  );

  assign cnt_en    = is_load || is_query || cmd_i.cnt_rd || cmd_i.upd;
  assign cnt_we    = is_load || cmd_i.upd;
  assign cnt_addr  = (is_load || is_query) ? in_word_i.entry_index : scan_q;
  assign cnt_wdata = is_load ? '0 : cnt_new;

  rrhc_ram #(
    .WIDTH ($bits(rrhc_pkg::count_t)),
    .DEPTH (rrhc_pkg::TableEntries)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .en_i    (cnt_en),
    .we_i    (cnt_we),
    .addr_i  (cnt_addr),
    .wdata_i (cnt_wdata),
    .rdata_o (cnt_rdata)
  );

  // window: start - margin < pos < end + margin, all 33 bit wide
  logic lo_ok, hi_ok, win;
  assign lo_ok = ({1'b0, sn_pos_q} + {1'b0, margin_q}) > {1'b0, ent_rdata.start};
  assign hi_ok = {1'b0, sn_pos_q} < ({1'b0, ent_rdata.stop} + {1'b0, margin_q});
  assign win   = !sn_inv_q && lo_ok && hi_ok;

  assign cnt_new.totals = sn_inv_q ? cnt_rdata.totals : rrhc_pkg::sat_inc(cnt_rdata.totals);
  assign cnt_new.hits   = win ? rrhc_pkg::sat_inc(cnt_rdata.hits) : cnt_rdata.hits;

  // status
  assign sts_o.tally_req = is_byte && (c == rrhc_pkg::ChNewline)
                        && (name_chars_q != '0) && pos_chars_q;
  assign sts_o.too_long  = too_long_q;
  assign sts_o.is_query  = in_word_i.func == rrhc_pkg::FuncQuery;
  assign sts_o.hit       = entry_valid_q[scan_q] && (ent_rdata.len == sn_len_q)
                        && (ent_rdata.name == sn_name_q);
  assign sts_o.scan_last = scan_q == IdxW'(rrhc_pkg::TableEntries - 1);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // parser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q  <= 1'b0;
      star_seen_q    <= 1'b0;
      too_long_q     <= 1'b0;
      pos_chars_q    <= 1'b0;
      digits_ended_q <= 1'b0;
      pos_invalid_q  <= 1'b0;
      tab_count_q    <= '0;
      name_buf_q     <= '0;
      name_chars_q   <= '0;
      pos_q          <= '0;
    end else if (is_byte) begin
      if (c == rrhc_pkg::ChNewline) begin
        line_active_q  <= 1'b1;
        star_seen_q    <= 1'b0;
        too_long_q     <= 1'b0;
        pos_chars_q    <= 1'b0;
        digits_ended_q <= 1'b0;
        pos_invalid_q  <= 1'b0;
        tab_count_q    <= '0;
        name_buf_q     <= '0;
        name_chars_q   <= '0;
        pos_q          <= '0;
      end else if (c == rrhc_pkg::ChAt) begin
        line_active_q <= 1'b0;
      end else if (line_active_q && c == rrhc_pkg::ChStar) begin
        star_seen_q <= 1'b1;
      end else if (line_active_q && c == rrhc_pkg::ChTab) begin
        if (tab_count_q < rrhc_pkg::TabSat) tab_count_q <= tab_count_q + 3'd1;
      end else if (line_active_q) begin
        if (!star_seen_q) begin
          if (name_chars_q < rrhc_pkg::LenW'(rrhc_pkg::NameChars)) begin
            name_buf_q[8*name_chars_q[2:0] +: 8] <= c;
            name_chars_q <= name_chars_q + 4'd1;
          end else begin
            too_long_q <= 1'b1;
          end
        end
        if (tab_count_q == rrhc_pkg::PosField) begin
          if (!digits_ended_q) begin
            if (is_digit) begin
              pos_q <= pos_next;
            end else begin
              digits_ended_q <= 1'b1;
              if (!pos_chars_q) pos_invalid_q <= 1'b1;
            end
          end
          pos_chars_q <= 1'b1;
        end
      end
    end
  end

  // snapshot, scan slot, query slot
  always_ff @(posedge clk_i) begin
    if (sts_o.tally_req) begin
      sn_name_q <= name_buf_q;
      sn_len_q  <= name_chars_q;
      sn_pos_q  <= pos_q;
      sn_inv_q  <= pos_invalid_q;
    end
    if (is_query) qidx_q <= in_word_i.entry_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (sts_o.tally_req) begin
      scan_q <= '0;
    end else if (cmd_i.scan_next) begin
      scan_q <= scan_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rrhc_pkg::TableEntries; i++) entry_valid_q[i] <= 1'b0;
    end else if (is_load) begin
      entry_valid_q[in_word_i.entry_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= rrhc_pkg::MarginReset;
    end else if (cfg_valid_i) begin
      margin_q <= cfg_data_i;
    end
  end

  // unmatched counter and result register
  logic [31:0] unm_next;
  assign unm_next = sn_inv_q ? unm_q : rrhc_pkg::sat_inc(unm_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unm_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.unm) unm_q <= unm_next;
      if (cmd_i.upd || cmd_i.unm || cmd_i.qry) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      out_q.kind            <= rrhc_pkg::KindRecord;
      out_q.matched_index   <= scan_q;
      out_q.name_known      <= 1'b1;
      out_q.in_window       <= win;
      out_q.position_bad    <= sn_inv_q;
      out_q.record_position <= sn_pos_q;
      out_q.hit_count       <= cnt_new.hits;
      out_q.total_count     <= cnt_new.totals;
      out_q.unmatched_count <= unm_q;
    end else if (cmd_i.unm) begin
      out_q.kind            <= rrhc_pkg::KindRecord;
      out_q.matched_index   <= '0;
      out_q.name_known      <= 1'b0;
      out_q.in_window       <= 1'b0;
      out_q.position_bad    <= sn_inv_q;
      out_q.record_position <= sn_pos_q;
      out_q.hit_count       <= '0;
      out_q.total_count     <= '0;
      out_q.unmatched_count <= unm_next;
    end else if (cmd_i.qry) begin
      out_q.kind            <= rrhc_pkg::KindQuery;
      out_q.matched_index   <= qidx_q;
      out_q.name_known      <= entry_valid_q[qidx_q];
      out_q.in_window       <= 1'b0;
      out_q.position_bad    <= 1'b0;
      out_q.record_position <= '0;
      out_q.hit_count       <= entry_valid_q[qidx_q] ? cnt_rdata.hits : '0;
      out_q.total_count     <= entry_valid_q[qidx_q] ? cnt_rdata.totals : '0;
      out_q.unmatched_count <= unm_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[rtl/record_region_hit_counter.sv]
// Record region hit counter, top level.
// Depends on rrhc_pkg, rrhc_ctrl and rrhc_dp.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_word_i): one word per item.
//    func load writes a table slot and clears its counts; func stream
//    byte feeds the record parser; func query reads a slot's counts and
//    answers from state StQout once the output register is free.
//  - A newline byte that closes a record with a name and a position starts
//    a linear search of the 64 slots: StSrd reads the single port entry
//    memory, StScmp compares and reads the counts. A hit goes to StCwin;
//    a miss on the last slot or an overflowed name goes to StUout.
//  - Output channel (out_valid_o / out_stall_i / out_word_o): at most one
//    word per item. The output register lets the next input word in while
//    a result waits; a stalled receiver holds the block only when a second
//    result is ready.
//  - Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): window margin,
//    always ready; write it only while the block is idle.
//  - Reset clears parser state, valid bits, unmatched count and margin
//    (to 5000). Entry memories are not cleared: slots become valid on load.
module record_region_hit_counter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rrhc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rrhc_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  rrhc_pkg::cmd_t cmd;
  rrhc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  rrhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrhc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

[rtl/rrhc_chk.sv]
// Port level checker for the record region hit counter, bound to the top.
// Depends on rrhc_pkg and record_region_hit_counter.
module rrhc_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input rrhc_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rrhc_pkg::out_word_t out_word_o
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("held result changed");

  // a query keeps the block busy while its counts are read
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.func == rrhc_pkg::FuncQuery |=> in_stall_o)
    else $error("query did not occupy the block");

  // a table load leaves the block free to take the next word
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.func == rrhc_pkg::FuncLoad |=> !in_stall_o)
    else $error("load did not finish in one cycle");

  // an unknown record name reports no slot and no counts
  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == rrhc_pkg::KindRecord && !out_word_o.name_known
    |-> out_word_o.matched_index == '0 && out_word_o.hit_count == '0
        && out_word_o.total_count == '0 && !out_word_o.in_window)
    else $error("unknown name with slot data");

endmodule

bind record_region_hit_counter rrhc_chk u_rrhc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
